>>> sv/sphere_view_cone_cull_top_assert.svh
`ifndef SPHERE_VIEW_CONE_CULL_TOP_ASSERT_SVH
`define SPHERE_VIEW_CONE_CULL_TOP_ASSERT_SVH

// implication checked at every rising edge outside reset
`define SVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svc implication check failed");

// condition that must never be seen outside reset
`define SVC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("svc forbidden condition seen");

`endif

>>> sv/svc_pkg.sv
package svc_pkg;

  // fraction bits of positions, scales and radius
  localparam int unsigned FRAC_BITS = 16;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // cycles from accepted start to the result strobe
  localparam int unsigned LATENCY = 11;

  // radius = floor((9*m + 3*2^(F-1)) / 10): bias term and reciprocal of five
  localparam logic [34:0] RADIUS_BIAS = 35'(3) << (FRAC_BITS - 1);
  localparam logic [34:0] RECIP5      = 35'd27487790695; // ceil(2^37 / 5)
  localparam int unsigned RECIP_SHIFT = 37;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_VIEW_DIR,
    REG_TAN_VERTICAL,
    REG_TAN_HORIZONTAL,
    REG_NEAR_DEPTH,
    REG_FAR_DEPTH
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
    logic [47:0]        view_dir;
    logic [23:0]        tan_vertical;
    logic [23:0]        tan_horizontal;
    logic signed [31:0] near_depth;
    logic signed [31:0] far_depth;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    camera_x:       32'sd0,
    camera_y:       32'sd0,
    camera_z:       32'sd0,
    view_dir:       48'h4000_0000_0000,
    tan_vertical:   24'h01_0000,
    tan_horizontal: 24'h01_0000,
    near_depth:     32'sd6554,
    far_depth:      32'sd65536000
  };

endpackage

>>> sv/svc_cfg.sv
module svc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [svc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output svc_pkg::cfg_t                  cfg_o
);

  svc_pkg::cfg_t cfg_d, cfg_q;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (svc_pkg::reg_idx_e'(cfg_idx_i))
        svc_pkg::REG_CAMERA_X:       cfg_d.camera_x       = $signed(cfg_data_i[31:0]);
        svc_pkg::REG_CAMERA_Y:       cfg_d.camera_y       = $signed(cfg_data_i[31:0]);
        svc_pkg::REG_CAMERA_Z:       cfg_d.camera_z       = $signed(cfg_data_i[31:0]);
        svc_pkg::REG_VIEW_DIR:       cfg_d.view_dir       = cfg_data_i;
        svc_pkg::REG_TAN_VERTICAL:   cfg_d.tan_vertical   = cfg_data_i[23:0];
        svc_pkg::REG_TAN_HORIZONTAL: cfg_d.tan_horizontal = cfg_data_i[23:0];
        svc_pkg::REG_NEAR_DEPTH:     cfg_d.near_depth     = $signed(cfg_data_i[31:0]);
        svc_pkg::REG_FAR_DEPTH:      cfg_d.far_depth      = $signed(cfg_data_i[31:0]);
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= svc_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/sphere_view_cone_cull_top.sv
// channel   dir  handshake            payload
// item      in   start / busy         object_tag_i, pos_{x,y,z}_i, scale_{x,y,z}_i
// result    out  visible_valid_o      visible_tag_o
// config    in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// one object enters per clock; busy stays low, every stage advances each cycle
// a kept object's tag is strobed after the eleven register stages of the multiply chain
//   (depth, depth squared, limit, limit squared)
// reset clears the valid bits and loads register defaults, no clearing pass
// the receiver cannot stall, so the pipeline never holds
module sphere_view_cone_cull_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [15:0]                    object_tag_i,
  input  logic signed [31:0]             pos_x_i,
  input  logic signed [31:0]             pos_y_i,
  input  logic signed [31:0]             pos_z_i,
  input  logic signed [31:0]             scale_x_i,
  input  logic signed [31:0]             scale_y_i,
  input  logic signed [31:0]             scale_z_i,
  input  logic                           cfg_we_i,
  input  logic [svc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           visible_valid_o,
  output logic [15:0]                    visible_tag_o
);

  svc_pkg::cfg_t cfg;
  logic          accept;

  // valid bits of stages one to ten, output strobe, tag line
  logic [svc_pkg::LATENCY-2:0] vld_q;
  logic                        out_vld_d, out_vld_q;
  logic [15:0]                 tag_q [svc_pkg::LATENCY];

  // stage 1: offsets and largest scale
  logic signed [31:0] pos_w [3];
  logic signed [31:0] cam_w [3];
  logic signed [31:0] scale_w [3];
  logic [31:0]        smag_w [3];
  logic signed [32:0] d1_d [3], d1_q [3];
  logic [31:0]        m1_d, m1_q;

  // stage 2: depth terms, squared offsets, radius numerator
  logic signed [15:0] f_w [3];
  logic signed [65:0] sqf_w [3];
  logic signed [48:0] pd2_d [3], pd2_q [3];
  logic [63:0]        sq2_d [3], sq2_q [3];
  logic [34:0]        v_w;
  logic [33:0]        u2_d, u2_q;

  // stage 3: depth, distance squared, radius partial products
  logic signed [49:0] depth3_d, depth3_q;
  logic [65:0]        dist3_d, dist3_q;
  logic [51:0]        rph3_d, rph3_q, rpl3_d, rpl3_q;

  // stage 4: radius, depth magnitude and sign, tangent pick
  logic [68:0]        rfull_w;
  logic [31:0]        radius4_d, radius4_q;
  logic [48:0]        dmag4_d, dmag4_q;
  logic               dneg4_d, dneg4_q;
  logic [23:0]        t4_d, t4_q;
  logic signed [49:0] depth4_q;
  logic [65:0]        dist4_q;

  // stage 5: near/far test, partial products of depth squared and depth*tangent
  logic signed [33:0] near_w, far_w, rad34_w, nl_w, fl_w;
  logic signed [47:0] nl48_w, fl48_w;
  logic [23:0]        ah_w;
  logic [24:0]        al_w;
  logic               cull5_d, cull5_q;
  logic [47:0]        hh5_d, hh5_q, ph5_d, ph5_q;
  logic [48:0]        hl5_d, hl5_q, pl5_d, pl5_q;
  logic [49:0]        ll5_d, ll5_q;
  logic [31:0]        radius5_q;
  logic [65:0]        dist5_q;
  logic               dneg5_q;

  // stage 6: depth squared and depth*tangent
  logic [97:0]        dsq6_d, dsq6_q;
  logic [72:0]        prod6_d, prod6_q;
  logic [31:0]        radius6_q;
  logic [65:0]        dist6_q;
  logic               dneg6_q, cull6_q;

  // stage 7: lateral square and limit
  logic [93:0]        dist28_w;
  logic [61:0]        rad_w;
  logic [93:0]        lat7_d, lat7_q;
  logic [73:0]        lim7_d, lim7_q;
  logic               cull7_d, cull7_q;

  // stage 8: limit rounded up
  logic [57:0]        lq8_d, lq8_q;
  logic [93:0]        lat8_q;
  logic               cull8_q;

  // stage 9: limit square partial products
  logic [28:0]        qh_w, ql_w;
  logic [57:0]        qhh9_d, qhh9_q, qhl9_d, qhl9_q, qll9_d, qll9_q;
  logic [93:0]        lat9_q;
  logic               cull9_q;

  // stage 10: limit squared
  logic [115:0]       lsq10_d, lsq10_q;
  logic [93:0]        lat10_q;
  logic               cull10_q;

  svc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1 logic
  always_comb begin
    pos_w[0]   = pos_x_i;
    pos_w[1]   = pos_y_i;
    pos_w[2]   = pos_z_i;
    cam_w[0]   = cfg.camera_x;
    cam_w[1]   = cfg.camera_y;
    cam_w[2]   = cfg.camera_z;
    scale_w[0] = scale_x_i;
    scale_w[1] = scale_y_i;
    scale_w[2] = scale_z_i;
    for (int i = 0; i < 3; i++) begin
      smag_w[i] = scale_w[i][31] ? 32'(-scale_w[i]) : 32'(scale_w[i]);
      d1_d[i]   = 33'(pos_w[i]) - 33'(cam_w[i]);
    end
    m1_d = smag_w[0];
    if (smag_w[1] > m1_d) begin
      m1_d = smag_w[1];
    end
    if (smag_w[2] > m1_d) begin
      m1_d = smag_w[2];
    end
  end

  // stage 2 logic
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_w[i]   = $signed(cfg.view_dir[i*16 +: 16]);
      pd2_d[i] = 49'(d1_q[i]) * 49'(f_w[i]);
      sqf_w[i] = 66'(d1_q[i]) * 66'(d1_q[i]);
      sq2_d[i] = sqf_w[i][63:0];
    end
    v_w  = {m1_q, 3'd0} + 35'(m1_q) + svc_pkg::RADIUS_BIAS;
    u2_d = v_w[34:1];
  end

  // stage 3 logic
  always_comb begin
    depth3_d = 50'(pd2_q[0]) + 50'(pd2_q[1]) + 50'(pd2_q[2]);
    dist3_d  = 66'(sq2_q[0]) + 66'(sq2_q[1]) + 66'(sq2_q[2]);
    rph3_d   = 52'(u2_q[33:17]) * 52'(svc_pkg::RECIP5);
    rpl3_d   = 52'(u2_q[16:0]) * 52'(svc_pkg::RECIP5);
  end

  // stage 4 logic: quotient by five, depth sign and tangent for that side
  always_comb begin
    rfull_w   = {rph3_q, 17'd0} + 69'(rpl3_q);
    radius4_d = rfull_w[svc_pkg::RECIP_SHIFT +: 32];
    dneg4_d   = depth3_q[49];
    dmag4_d   = dneg4_d ? 49'(-depth3_q) : 49'(depth3_q);
    if (!dneg4_d) begin
      t4_d = (cfg.tan_vertical > cfg.tan_horizontal) ? cfg.tan_vertical : cfg.tan_horizontal;
    end else begin
      t4_d = (cfg.tan_vertical < cfg.tan_horizontal) ? cfg.tan_vertical : cfg.tan_horizontal;
    end
  end

  // stage 5 logic
  always_comb begin
    near_w  = 34'(cfg.near_depth);
    far_w   = 34'(cfg.far_depth);
    rad34_w = $signed({2'b00, radius4_q});
    nl_w    = near_w - rad34_w;
    fl_w    = far_w + rad34_w;
    nl48_w  = {nl_w, 14'd0};
    fl48_w  = {fl_w, 14'd0};
    cull5_d = (depth4_q < 50'(nl48_w)) || (depth4_q > 50'(fl48_w));
    ah_w    = dmag4_q[48:25];
    al_w    = dmag4_q[24:0];
    hh5_d   = 48'(ah_w) * 48'(ah_w);
    hl5_d   = 49'(ah_w) * 49'(al_w);
    ll5_d   = 50'(al_w) * 50'(al_w);
    ph5_d   = 48'(ah_w) * 48'(t4_q);
    pl5_d   = 49'(al_w) * 49'(t4_q);
  end

  // stage 6 logic
  always_comb begin
    dsq6_d  = {hh5_q, 50'd0} + 98'({hl5_q, 26'd0}) + 98'(ll5_q);
    prod6_d = {ph5_q, 25'd0} + 73'(pl5_q);
  end

  // stage 7 logic: lateral square floored at zero, cone limit, negative limit culls
  always_comb begin
    dist28_w = {dist6_q, 28'd0};
    rad_w    = {radius6_q, 30'd0};
    if (98'(dist28_w) > dsq6_q) begin
      lat7_d = 94'(98'(dist28_w) - dsq6_q);
    end else begin
      lat7_d = '0;
    end
    if (dneg6_q) begin
      lim7_d = 74'(rad_w) - 74'(prod6_q);
    end else begin
      lim7_d = 74'(prod6_q) + 74'(rad_w);
    end
    cull7_d = cull6_q || (dneg6_q && (prod6_q > 73'(rad_w)));
  end

  // stage 8 logic: round limit up to the depth scale
  assign lq8_d = lim7_q[73:16] + {57'd0, |lim7_q[15:0]};

  // stage 9 logic
  always_comb begin
    qh_w   = lq8_q[57:29];
    ql_w   = lq8_q[28:0];
    qhh9_d = 58'(qh_w) * 58'(qh_w);
    qhl9_d = 58'(qh_w) * 58'(ql_w);
    qll9_d = 58'(ql_w) * 58'(ql_w);
  end

  // stage 10 logic
  assign lsq10_d = {qhh9_q, 58'd0} + 116'({qhl9_q, 30'd0}) + 116'(qll9_q);

  // final compare against the squared limit
  assign out_vld_d = vld_q[svc_pkg::LATENCY-2] && !cull10_q && (116'(lat10_q) <= lsq10_q);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[svc_pkg::LATENCY-3:0], accept};
      out_vld_q <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    tag_q[0] <= object_tag_i;
    for (int k = 1; k < svc_pkg::LATENCY; k++) begin
      tag_q[k] <= tag_q[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      d1_q[i]  <= d1_d[i];
      pd2_q[i] <= pd2_d[i];
      sq2_q[i] <= sq2_d[i];
    end
    m1_q      <= m1_d;
    u2_q      <= u2_d;
    depth3_q  <= depth3_d;
    dist3_q   <= dist3_d;
    rph3_q    <= rph3_d;
    rpl3_q    <= rpl3_d;
    radius4_q <= radius4_d;
    dmag4_q   <= dmag4_d;
    dneg4_q   <= dneg4_d;
    t4_q      <= t4_d;
    depth4_q  <= depth3_q;
    dist4_q   <= dist3_q;
    cull5_q   <= cull5_d;
    hh5_q     <= hh5_d;
    hl5_q     <= hl5_d;
    ll5_q     <= ll5_d;
    ph5_q     <= ph5_d;
    pl5_q     <= pl5_d;
    radius5_q <= radius4_q;
    dist5_q   <= dist4_q;
    dneg5_q   <= dneg4_q;
    dsq6_q    <= dsq6_d;
    prod6_q   <= prod6_d;
    radius6_q <= radius5_q;
    dist6_q   <= dist5_q;
    dneg6_q   <= dneg5_q;
    cull6_q   <= cull5_q;
    lat7_q    <= lat7_d;
    lim7_q    <= lim7_d;
    cull7_q   <= cull7_d;
    lq8_q     <= lq8_d;
    lat8_q    <= lat7_q;
    cull8_q   <= cull7_q;
    qhh9_q    <= qhh9_d;
    qhl9_q    <= qhl9_d;
    qll9_q    <= qll9_d;
    lat9_q    <= lat8_q;
    cull9_q   <= cull8_q;
    lsq10_q   <= lsq10_d;
    lat10_q   <= lat9_q;
    cull10_q  <= cull9_q;
  end

  assign visible_valid_o = out_vld_q;
  assign visible_tag_o   = tag_q[svc_pkg::LATENCY-1];

endmodule

>>> sv/svc_chk.sv
`include "sphere_view_cone_cull_top_assert.svh"

module svc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [15:0] object_tag_i,
  input logic        visible_valid_o,
  input logic [15:0] visible_tag_o
);

  // every result traces back to an earlier accepted transaction
  `SVC_ASSERT_IMP(a_result_from_item, clk_i, rst_ni, visible_valid_o, $past(start && !busy, svc_pkg::LATENCY))

  // the strobed tag is the one that entered with that transaction
  `SVC_ASSERT_IMP(a_result_tag, clk_i, rst_ni, visible_valid_o, visible_tag_o == $past(object_tag_i, svc_pkg::LATENCY))

  // no stale result right after reset
  `SVC_ASSERT_IMP(a_quiet_after_reset, clk_i, rst_ni, !$past(rst_ni), !visible_valid_o)

  // the pipeline never refuses a transaction
  `SVC_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)

endmodule

bind sphere_view_cone_cull_top svc_chk u_svc_chk (.*);
